@@ src/irpp_pkg.sv @@
// Package for the IR payload packetizer: constants and shared types.
// No dependencies; used by irpp_framer, irpp_emitter and the top level.
package irpp_pkg;

    // Largest payload of one packet and largest message, in bytes
    localparam logic [11:0] MAX_PAYLOAD = 12'd250;
    localparam logic [11:0] MAX_MESSAGE = 12'd2048;

    // Framing overhead counted in the length byte (checksum high and low)
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    // Room for the framed bytes caused by one payload byte (at most 7 occur)
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [CNT_W-1:0] res_cnt_t;

    typedef struct packed {
        logic       message_end;
        logic       packet_end;
        logic [7:0] framed_byte;
    } out_item_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        res_cnt_t                    count;
    } result_set_t;

endpackage

@@ src/irpp_framer.sv @@
// Packet framing state and the single-pass logic that turns one payload byte
// into its list of framed bytes. Depends on irpp_pkg.
module irpp_framer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [7:0]           data_byte,
    input  logic                 first_of_message,
    input  logic [11:0]          message_length,
    output irpp_pkg::result_set_t res
);

    logic [7:0]  packet_number_reg,     packet_number_next;
    logic [11:0] bytes_remaining_reg,   bytes_remaining_next;
    logic [7:0]  packet_bytes_left_reg, packet_bytes_left_next;
    logic [15:0] running_sum_reg,       running_sum_next;
    logic        message_active_reg,    message_active_next;
    logic        trailer_due_reg,       trailer_due_next;

    logic [11:0] len_sat;
    logic        act;
    logic [7:0]  pn;
    logic [11:0] br;
    logic [7:0]  pbl;
    logic [15:0] sum;
    logic        td;
    logic        hdr;
    logic [11:0] size;
    logic [7:0]  lbyte;
    logic        td1;
    logic [7:0]  pbl1;
    logic [15:0] sum1;
    logic [15:0] sum2;
    logic [7:0]  pbl2;
    logic [11:0] br2;
    logic        close;
    logic        last;
    logic [7:0]  pn2;
    logic [15:0] tsum;
    irpp_pkg::res_cnt_t k;

    always_comb
    begin
        len_sat = (message_length > irpp_pkg::MAX_MESSAGE) ? irpp_pkg::MAX_MESSAGE
                                                           : message_length;
        // a first byte restarts everything; zero length leaves the block idle
        act = first_of_message ? (len_sat != 12'd0) : message_active_reg;
        pn  = first_of_message ? 8'd0  : packet_number_reg;
        br  = first_of_message ? len_sat : bytes_remaining_reg;
        pbl = first_of_message ? 8'd0  : packet_bytes_left_reg;
        sum = first_of_message ? 16'd0 : running_sum_reg;
        td  = first_of_message ? 1'b0  : trailer_due_reg;

        hdr   = (pbl == 8'd0);
        size  = (br < irpp_pkg::MAX_PAYLOAD) ? br : irpp_pkg::MAX_PAYLOAD;
        lbyte = size[7:0] + irpp_pkg::LEN_OVERHEAD;
        td1   = hdr ? ((size == br) && (size == irpp_pkg::MAX_PAYLOAD)) : td;
        pbl1  = hdr ? size[7:0] : pbl;
        sum1  = hdr ? ({8'd0, pn} + {8'd0, lbyte}) : sum;
        sum2  = sum1 + {8'd0, data_byte};
        pbl2  = pbl1 - 8'd1;
        br2   = br - 12'd1;
        close = (pbl2 == 8'd0);
        last  = close && (br2 == 12'd0);
        pn2   = pn + 8'd1;
        tsum  = {8'd0, pn2} + {8'd0, irpp_pkg::LEN_OVERHEAD};

        res = '0;
        k   = '0;
        if (act)
        begin
            if (hdr)
            begin
                res.items[k] = '{message_end: 1'b0, packet_end: 1'b0, framed_byte: pn};
                k = k + 1'b1;
                res.items[k] = '{message_end: 1'b0, packet_end: 1'b0, framed_byte: lbyte};
                k = k + 1'b1;
            end
            res.items[k] = '{message_end: 1'b0, packet_end: 1'b0, framed_byte: data_byte};
            k = k + 1'b1;
            if (close)
            begin
                res.items[k] = '{message_end: 1'b0, packet_end: 1'b0,
                                 framed_byte: sum2[15:8]};
                k = k + 1'b1;
                res.items[k] = '{message_end: last && !td1, packet_end: 1'b1,
                                 framed_byte: sum2[7:0]};
                k = k + 1'b1;
                // empty trailer packet after a full final packet
                if (last && td1)
                begin
                    res.items[k] = '{message_end: 1'b0, packet_end: 1'b0, framed_byte: pn2};
                    k = k + 1'b1;
                    res.items[k] = '{message_end: 1'b0, packet_end: 1'b0,
                                     framed_byte: irpp_pkg::LEN_OVERHEAD};
                    k = k + 1'b1;
                    res.items[k] = '{message_end: 1'b0, packet_end: 1'b0,
                                     framed_byte: tsum[15:8]};
                    k = k + 1'b1;
                    res.items[k] = '{message_end: 1'b1, packet_end: 1'b1,
                                     framed_byte: tsum[7:0]};
                    k = k + 1'b1;
                end
            end
        end
        res.count = k;
    end

    always_comb
    begin
        packet_number_next     = packet_number_reg;
        bytes_remaining_next   = bytes_remaining_reg;
        packet_bytes_left_next = packet_bytes_left_reg;
        running_sum_next       = running_sum_reg;
        message_active_next    = message_active_reg;
        trailer_due_next       = trailer_due_reg;
        if (load)
        begin
            if (act)
            begin
                packet_bytes_left_next = pbl2;
                bytes_remaining_next   = br2;
                running_sum_next       = close ? 16'd0 : sum2;
                if (close)
                    packet_number_next = (last && td1) ? (pn + 8'd2) : pn2;
                else
                    packet_number_next = pn;
                message_active_next = !last;
                trailer_due_next    = last ? 1'b0 : td1;
            end
            else if (first_of_message)
            begin
                message_active_next = 1'b0;
                trailer_due_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_number_reg     <= '0;
            bytes_remaining_reg   <= '0;
            packet_bytes_left_reg <= '0;
            running_sum_reg       <= '0;
            message_active_reg    <= 1'b0;
            trailer_due_reg       <= 1'b0;
        end
        else
        begin
            packet_number_reg     <= packet_number_next;
            bytes_remaining_reg   <= bytes_remaining_next;
            packet_bytes_left_reg <= packet_bytes_left_next;
            running_sum_reg       <= running_sum_next;
            message_active_reg    <= message_active_next;
            trailer_due_reg       <= trailer_due_next;
        end
    end

endmodule

@@ src/irpp_emitter.sv @@
// Result register holding the framed bytes of one request and the sequencer
// that hands them out one per cycle while out_ready is high. Depends on irpp_pkg.
module irpp_emitter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  irpp_pkg::result_set_t res,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output irpp_pkg::out_item_t   out_item
);

    localparam int CNT_W_PLUS = irpp_pkg::CNT_W + 1;

    irpp_pkg::out_item_t [irpp_pkg::MAX_RESULTS-1:0] buf_reg;
    irpp_pkg::res_cnt_t idx_reg, idx_next;
    irpp_pkg::res_cnt_t rem_reg, rem_next;
    logic               pop;

    assign out_valid = (rem_reg != '0);
    assign out_item  = buf_reg[idx_reg];
    assign pop       = out_valid && out_ready;
    // take the next request as the last byte of this one leaves
    assign free      = (rem_reg == '0) || ((rem_reg == irpp_pkg::res_cnt_t'(1)) && pop);

    always_comb
    begin
        idx_next = idx_reg;
        rem_next = rem_reg;
        if (load)
        begin
            idx_next = '0;
            rem_next = res.count;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 1'b1;
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= res.items;
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, idx_reg} + {1'b0, rem_reg}) <= (CNT_W_PLUS)'(irpp_pkg::MAX_RESULTS))
        else $error("read pointer ran past the result set");

    a_msg_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.message_end |-> out_item.packet_end)
        else $error("message end without packet end");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (rem_reg == $past(res.count)) && (idx_reg == '0))
        else $error("result set not loaded");

    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !load |=> (idx_reg == $past(idx_reg) + 1'b1)
                         && (rem_reg == $past(rem_reg) - 1'b1))
        else $error("sequencer did not advance on a taken byte");

endmodule

@@ src/ir_payload_packetizer_top.sv @@
// Top level of the IR payload packetizer: stream ports, framer and emitter.
// Depends on irpp_pkg, irpp_framer and irpp_emitter.
//
//  channel   dir  tdata                               tuser              tlast
//  s_axis    in   [7:0] data_byte, [19:8] msg length  first_of_message   -
//  m_axis    out  [7:0] framed_byte                   message_end        packet_end
//
// A payload byte is framed in the cycle it is taken; its framed bytes leave
// from the next cycle on, 0 to 7 of them (none for a dropped byte; header,
// checksum and trailer bytes add to the one payload byte).
// The next request is taken in the cycle the last framed byte leaves, so
// bytes that frame to one result flow at one per cycle while m_axis_tready is high.
// Output stalls hold the input off; no clearing pass after reset.
module ir_payload_packetizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [19:8] message_length, rest 0
    input  logic        s_axis_tuser,   // [0] first_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] framed_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] message_end
);

    irpp_pkg::result_set_t res;
    irpp_pkg::out_item_t   out_item;
    logic                  load;
    logic                  free;

    assign s_axis_tready = free;
    assign load          = s_axis_tvalid && free;

    irpp_framer u_framer
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .data_byte        (s_axis_tdata[7:0]),
        .first_of_message (s_axis_tuser),
        .message_length   (s_axis_tdata[19:8]),
        .res              (res)
    );

    irpp_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = out_item.framed_byte;
    assign m_axis_tlast = out_item.packet_end;
    assign m_axis_tuser = out_item.message_end;

endmodule
